// ===== src/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared codes and controller/datapath command and status types for the
// sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned OccWidth = 7;

  typedef struct packed {
    logic cap;
    logic rd_tail;
    logic rd_next;
    logic rd_head;
    logic shift;
    logic place;
    logic pop;
    logic rej_full;
    logic rej_empty;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic gt;
    logic pos_one;
  } stat_t;

endpackage

// ===== src/smpq_if.sv =====
// ----------------------------------------------------------------------------
// smpq channel interfaces
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
interface smpq_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] value_in;

  modport source (output valid, output operation, output value_in, input ready);
  modport sink   (input valid, input operation, input value_in, output ready);
endinterface

interface smpq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [31:0]                    value_out;
  logic [1:0]                            status;
  logic [smpq_pkg::OccWidth-1:0]         occupancy;

  modport source (output valid, output value_out, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input value_out, input status, input occupancy,
                  output ready);
endinterface

// ===== src/smpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// smpq_ctrl
// Sequencer for insert walks, removals and result handshake.
// ----------------------------------------------------------------------------
module smpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  smpq_pkg::stat_t stat_i,
  output smpq_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StIns   = 3'd1;
  localparam logic [2:0] StPlace = 3'd2;
  localparam logic [2:0] StRem   = 3'd3;
  localparam logic [2:0] StResp  = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StResp);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_op_i == smpq_pkg::OP_INSERT) begin
            if (stat_i.full) begin
              cmd_o.rej_full = 1'b1;
              state_d        = StResp;
            end else if (stat_i.empty) begin
              cmd_o.cap = 1'b1;
              state_d   = StPlace;
            end else begin
              cmd_o.cap     = 1'b1;
              cmd_o.rd_tail = 1'b1;
              state_d       = StIns;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.rej_empty = 1'b1;
              state_d         = StResp;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = StRem;
            end
          end
        end
      end
      StIns: begin
        if (stat_i.gt) begin
          cmd_o.shift = 1'b1;
          if (stat_i.pos_one) begin
            state_d = StPlace;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end else begin
          cmd_o.place = 1'b1;
          state_d     = StResp;
        end
      end
      StPlace: begin
        cmd_o.place = 1'b1;
        state_d     = StResp;
      end
      StRem: begin
        cmd_o.pop = 1'b1;
        state_d   = StResp;
      end
      StResp: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/smpq_dp.sv =====
// ----------------------------------------------------------------------------
// smpq_dp
// Circular sorted store, occupancy, insert walk pointer and result registers.
// ----------------------------------------------------------------------------
module smpq_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  smpq_pkg::cmd_t                cmd_i,
  output smpq_pkg::stat_t               stat_o,
  input  logic signed [31:0]            value_in_i,
  output logic signed [31:0]            value_out_o,
  output logic [1:0]                    status_o,
  output logic [smpq_pkg::OccWidth-1:0] occupancy_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem_q [DEPTH];

  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic signed [31:0] val_q;
  logic signed [31:0] rd_data_q;
  logic signed [31:0] res_value_q, res_value_d;
  logic [1:0]         res_status_q, res_status_d;

  logic [AW-1:0]      rd_log, rd_addr, wr_addr;
  logic               rd_en, wr_en;
  logic signed [31:0] wr_data;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign stat_o.empty   = (count_q == '0);
  assign stat_o.full    = (count_q == CW'(DEPTH));
  assign stat_o.gt      = (rd_data_q > val_q);
  assign stat_o.pos_one = (pos_q == AW'(1));

  always_comb begin
    rd_log = '0;
    if (cmd_i.rd_tail) begin
      rd_log = count_q[AW-1:0] - AW'(1);
    end else if (cmd_i.rd_next) begin
      rd_log = pos_q - AW'(2);
    end
  end

  assign rd_en   = cmd_i.rd_tail | cmd_i.rd_next | cmd_i.rd_head;
  assign rd_addr = phys(head_q, rd_log);
  assign wr_en   = cmd_i.shift | cmd_i.place;
  assign wr_addr = phys(head_q, pos_q);
  assign wr_data = cmd_i.shift ? rd_data_q : val_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    count_d      = count_q;
    head_d       = head_q;
    pos_d        = pos_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    if (cmd_i.cap) begin
      pos_d = count_q[AW-1:0];
    end
    if (cmd_i.shift) begin
      pos_d = pos_q - AW'(1);
    end
    if (cmd_i.place) begin
      count_d      = count_q + CW'(1);
      res_value_d  = '0;
      res_status_d = smpq_pkg::STATUS_DONE;
    end
    if (cmd_i.pop) begin
      count_d      = count_q - CW'(1);
      head_d       = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
      res_value_d  = rd_data_q;
      res_status_d = smpq_pkg::STATUS_DONE;
    end
    if (cmd_i.rej_full) begin
      res_value_d  = '0;
      res_status_d = smpq_pkg::STATUS_FULL;
    end
    if (cmd_i.rej_empty) begin
      res_value_d  = '0;
      res_status_d = smpq_pkg::STATUS_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    if (cmd_i.cap) begin
      val_q <= value_in_i;
    end
  end

  assign value_out_o = res_value_q;
  assign status_o    = res_status_q;
  assign occupancy_o = smpq_pkg::OccWidth'(count_q);

endmodule

// ===== src/sorted_min_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Sorted minimum priority queue
// Bounded ascending queue of signed 32-bit values with insert and remove-min.
// ----------------------------------------------------------------------------
// One operation is in flight at a time and each gives one result. An insert
// walks down from the largest stored value through the store, which has one
// read and one write port, shifting each stored value greater than the new
// one up by one entry, one entry a cycle. The store is a ring addressed from
// a head pointer, so removal moves no data; equal values leave in arrival
// order. Occupancy reports the low seven bits of the count after the
// operation.
module sorted_min_priority_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  smpq_in_if.sink           in_i,
  smpq_out_if.source        out_o
);

  smpq_pkg::cmd_t  cmd;
  smpq_pkg::stat_t stat;

  smpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  smpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_in_i  (in_i.value_in),
    .value_out_o (out_o.value_out),
    .status_o    (out_o.status),
    .occupancy_o (out_o.occupancy)
  );

endmodule

// ===== test/tb_sorted_min_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Sorted minimum priority queue testbench
// Drives insert and remove operations through the input channel and checks
// every result (removed value, status and occupancy) against a shadow queue
// kept in ascending order. Covers the value extremes, removal from an empty
// queue, insertion into a full queue, draining to empty, random traffic with
// idle cycles on both sides, and a long result stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_sorted_min_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH          = 64;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          TAIL_CYCLES    = DEPTH + 16;
  localparam int          HOLD_CYCLES    = 200;

  typedef struct packed {
    logic signed [31:0]                value;
    logic [1:0]                        status;
    logic [smpq_pkg::OccWidth-1:0]     occupancy;
  } queue_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  smpq_in_if  in_ch ();
  smpq_out_if out_ch ();

  sorted_min_priority_queue_top #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  logic signed [31:0] shadow_store[$];
  queue_result_t      pending_results[$];
  int                 error_count = 0;
  bit                 send_gaps_on = 1'b1;
  bit                 recv_stalls_on = 1'b1;
  int                 hold_request = 0;

  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic signed [31:0] val);
    queue_result_t res;
    int            pos;
    res.value  = '0;
    res.status = smpq_pkg::STATUS_DONE;
    if (op == smpq_pkg::OP_INSERT) begin
      if (shadow_store.size() >= DEPTH) begin
        res.status = smpq_pkg::STATUS_FULL;
      end else begin
        pos = shadow_store.size();
        while (pos > 0 && shadow_store[pos-1] > val) pos--;
        shadow_store.insert(pos, val);
      end
    end else if (shadow_store.size() == 0) begin
      res.status = smpq_pkg::STATUS_EMPTY;
    end else begin
      res.value = shadow_store.pop_front();
    end
    res.occupancy = smpq_pkg::OccWidth'(shadow_store.size());
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 8)) - 32'sd4;
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      3: v = $signed($urandom_range(0, 2000)) - 32'sd1000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_op(input logic op, input logic signed [31:0] val);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value_in  <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(apply_queue_op(op, val));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Result side: stall, take one transfer, check it.
  initial begin
    queue_result_t exp_res;
    int            stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = recv_stalls_on ? $urandom_range(0, 9) : 0;
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %0d status %0d occupancy %0d", $realtime,
                 out_ch.value_out, out_ch.status, out_ch.occupancy);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.value_out !== exp_res.value) begin
          $display("%0t: value_out expected %0d actual %0d", $realtime, exp_res.value,
                   out_ch.value_out);
          error_count++;
        end
        if (out_ch.status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp_res.status,
                   out_ch.status);
          error_count++;
        end
        if (out_ch.occupancy !== exp_res.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $realtime,
                   exp_res.occupancy, out_ch.occupancy);
          error_count++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("sorted_min_priority_queue_top regression: fail");
          $finish;
        end
      end
    end
  end

  task automatic test_directed();
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
    send_op(smpq_pkg::OP_REMOVE, 32'sd0);
    send_op(smpq_pkg::OP_INSERT, 32'sh7fff_ffff);
    send_op(smpq_pkg::OP_INSERT, 32'sh8000_0000);
    send_op(smpq_pkg::OP_INSERT, 32'sd0);
    send_op(smpq_pkg::OP_INSERT, -32'sd1);
    send_op(smpq_pkg::OP_INSERT, 32'sd1);
    send_op(smpq_pkg::OP_INSERT, 32'sd5);
    send_op(smpq_pkg::OP_INSERT, 32'sd5);
    send_op(smpq_pkg::OP_INSERT, -32'sd5);
    send_op(smpq_pkg::OP_INSERT, 32'sh5555_5555);
    send_op(smpq_pkg::OP_INSERT, 32'shaaaa_aaaa);
    send_op(smpq_pkg::OP_REMOVE, 32'shdead_beef);
    repeat (9) send_op(smpq_pkg::OP_REMOVE, 32'sd0);
    send_op(smpq_pkg::OP_REMOVE, 32'sh7fff_ffff);
    send_op(smpq_pkg::OP_INSERT, 32'sd7);
    send_op(smpq_pkg::OP_REMOVE, -32'sd1);
    drain_results();
  endtask

  task automatic test_full_and_empty();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b1;
    repeat (DEPTH) send_op(smpq_pkg::OP_INSERT, pick_value());
    send_op(smpq_pkg::OP_INSERT, 32'sh8000_0000);
    send_op(smpq_pkg::OP_INSERT, 32'sh7fff_ffff);
    send_op(smpq_pkg::OP_REMOVE, 32'sd0);
    send_op(smpq_pkg::OP_INSERT, pick_value());
    send_op(smpq_pkg::OP_INSERT, pick_value());
    repeat (DEPTH + 1) send_op(smpq_pkg::OP_REMOVE, pick_value());
    drain_results();
  endtask

  task automatic test_result_backpressure();
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    hold_request   = HOLD_CYCLES;
    repeat (12) send_op(smpq_pkg::OP_INSERT, pick_value());
    repeat (12) send_op(smpq_pkg::OP_REMOVE, pick_value());
    drain_results();
  endtask

  task automatic test_random_mix();
    int insert_pct;
    for (int seg = 0; seg < 15; seg++) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 80;
        1: insert_pct = 50;
        default: insert_pct = 25;
      endcase
      send_gaps_on   = ($urandom_range(0, 3) != 0);
      recv_stalls_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 50; n++) begin
        send_op(($urandom_range(0, 99) < insert_pct) ? smpq_pkg::OP_INSERT :
                smpq_pkg::OP_REMOVE, pick_value());
      end
      if (seg % 4 == 3) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = smpq_pkg::OP_INSERT;
    in_ch.value_in  = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_full_and_empty();
    test_result_backpressure();
    test_random_mix();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime,
               pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("sorted_min_priority_queue_top regression: pass");
    end else begin
      $display("sorted_min_priority_queue_top regression: fail");
    end
    $finish;
  end

endmodule
